// ===== design/bet_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bet_pkg;

  // defaults for the top-level parameters
  localparam int unsigned POSITION_WIDTH_DEF = 32;
  localparam int unsigned ANGLE_WIDTH_DEF    = 16;
  localparam int unsigned CORDIC_STEPS_DEF   = 16;

  // cordic datapath: magnitudes stay below 2^61 after prescale and growth
  localparam int unsigned CORDIC_W = 64;
  localparam int unsigned PRESCALE_TOP = 59;
  localparam int unsigned PHASE_W = 32;
  localparam int unsigned ATAN_ENTRIES = 24;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned THRESH_W   = 16;
  localparam logic [0:0] REG_MIN_DISTANCE = 1'b0;
  localparam logic [THRESH_W-1:0] MIN_DIST_RESET = 16'd655;
  localparam logic [2*THRESH_W-1:0] MIN_DIST_SQ_RESET = 32'd429025;

  // atan(2^-i) in binary angle units, 2^31 = pi
  localparam logic [PHASE_W-1:0] ATAN_UNITS [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  localparam logic [PHASE_W-1:0] PHASE_PI = 32'h8000_0000;

endpackage

`default_nettype wire

// ===== design/bearing_error_to_target.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   | valid     | stall     | payload
// ----------+-----------+-----------+---------------------------------------------
// in        | in_valid  | in_stall  | source_x/y, heading, target_x/y
// out       | out_valid | out_stall | valid_res, angle_error
// cfg (apb) | psel      | -         | paddr, pwrite, pwdata -> min_distance @ 0x0
//
// one request per cycle while in_stall is low; the pipeline has a difference stage,
// a prescale stage, one cordic iteration per pipeline stage and an output stage.
// rst_n is synchronous: it empties the pipeline and sets min_distance to 655.
// a result held on out_valid with out_stall high freezes every stage and
// raises in_stall in the same cycle; nothing is dropped or replayed.

module bearing_error_to_target
  import bet_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = POSITION_WIDTH_DEF,
  parameter int unsigned ANGLE_WIDTH    = ANGLE_WIDTH_DEF,
  parameter int unsigned CORDIC_STEPS   = CORDIC_STEPS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,

  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire signed [POSITION_WIDTH-1:0]  in_source_x,
  input  wire signed [POSITION_WIDTH-1:0]  in_source_y,
  input  wire signed [ANGLE_WIDTH-1:0]     in_heading,
  input  wire signed [POSITION_WIDTH-1:0]  in_target_x,
  input  wire signed [POSITION_WIDTH-1:0]  in_target_y,

  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             out_valid_res,
  output logic signed [ANGLE_WIDTH:0]      out_angle_error,

  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire        [CFG_ADDR_W-1:0]      paddr,
  input  wire        [CFG_DATA_W-1:0]      pwdata,
  output logic       [CFG_DATA_W-1:0]      prdata,
  output logic                             pready
);

  localparam int unsigned PW = POSITION_WIDTH;
  localparam int unsigned AW = ANGLE_WIDTH;
  localparam int unsigned N  = CORDIC_STEPS;
  localparam int unsigned PRESCALE = PRESCALE_TOP - PW;
  localparam logic [PHASE_W-1:0] ROUND_HALF = PHASE_W'(1) << (PHASE_W - 1 - AW);
  localparam logic [AW-1:0] ANGLE_HALF = AW'(1) << (AW - 1);

  // ---------------------------------------------------------------- config
  logic [THRESH_W-1:0]   min_dist_r;
  logic [2*THRESH_W-1:0] min_dist_sq_r;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[CFG_ADDR_W-1] == REG_MIN_DISTANCE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r    <= MIN_DIST_RESET;
      min_dist_sq_r <= MIN_DIST_SQ_RESET;
    end else begin
      if (cfg_wr) begin
        min_dist_r <= pwdata[THRESH_W-1:0];
      end
      min_dist_sq_r <= min_dist_r * min_dist_r;
    end
  end

  always_comb begin
    if (paddr[CFG_ADDR_W-1] == REG_MIN_DISTANCE) begin
      prdata = {{(CFG_DATA_W-THRESH_W){1'b0}}, min_dist_r};
    end else begin
      prdata = '0;
    end
  end

  // ---------------------------------------------------------------- flow
  logic en;
  logic out_valid_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // ---------------------------------------------------------------- stage 1: differences
  logic                 v1_r;
  logic signed [PW:0]   dx_r, dy_r;
  logic [PHASE_W-1:0]   hoff1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r    <= (PW+1)'(in_target_x) - (PW+1)'(in_source_x);
      dy_r    <= (PW+1)'(in_target_y) - (PW+1)'(in_source_y);
      // rounding offset minus heading, both in 32-bit angle units
      hoff1_r <= ROUND_HALF - {in_heading, {(PHASE_W-AW){1'b0}}};
    end
  end

  // ---------------------------------------------------------------- stage 2: magnitudes, prescale
  logic [PW:0]                 ax, ay;
  logic signed [CORDIC_W-1:0]  xe, ye;
  logic                        big_r;
  logic [2*THRESH_W-1:0]       sqx_r, sqy_r;

  logic                        v_r    [0:N];
  logic signed [CORDIC_W-1:0]  x_r    [0:N];
  logic signed [CORDIC_W-1:0]  y_r    [0:N];
  logic [PHASE_W-1:0]          z_r    [0:N];
  logic [PHASE_W-1:0]          hoff_r [0:N];
  logic                        far_r  [1:N];

  assign ax = dx_r[PW] ? (PW+1)'(-dx_r) : dx_r;
  assign ay = dy_r[PW] ? (PW+1)'(-dy_r) : dy_r;
  assign xe = {{(CORDIC_W-PW-1){dx_r[PW]}}, dx_r} <<< PRESCALE;
  assign ye = {{(CORDIC_W-PW-1){dy_r[PW]}}, dy_r} <<< PRESCALE;

  always_ff @(posedge clk) begin
    if (en) begin
      big_r     <= (|ax[PW:THRESH_W]) || (|ay[PW:THRESH_W]);
      sqx_r     <= ax[THRESH_W-1:0] * ax[THRESH_W-1:0];
      sqy_r     <= ay[THRESH_W-1:0] * ay[THRESH_W-1:0];
      hoff_r[0] <= hoff1_r;
      // left half plane: rotate by pi first
      if (xe < 0) begin
        x_r[0] <= -xe;
        y_r[0] <= -ye;
        z_r[0] <= PHASE_PI;
      end else begin
        x_r[0] <= xe;
        y_r[0] <= ye;
        z_r[0] <= '0;
      end
    end
  end

  // ---------------------------------------------------------------- cordic stages
  for (genvar k = 1; k <= N; k++) begin : g_stage
    logic signed [CORDIC_W-1:0] xs, ys;

    assign xs = x_r[k-1] >>> (k-1);
    assign ys = y_r[k-1] >>> (k-1);

    always_ff @(posedge clk) begin
      if (en) begin
        hoff_r[k] <= hoff_r[k-1];
        if (y_r[k-1] >= 0) begin
          x_r[k] <= x_r[k-1] + ys;
          y_r[k] <= y_r[k-1] - xs;
          z_r[k] <= z_r[k-1] + ATAN_UNITS[k-1];
        end else begin
          x_r[k] <= x_r[k-1] - ys;
          y_r[k] <= y_r[k-1] + xs;
          z_r[k] <= z_r[k-1] - ATAN_UNITS[k-1];
        end
      end
    end

    if (k == 1) begin : g_far
      // exact squared-distance test, done alongside the first iteration
      always_ff @(posedge clk) begin
        if (en) begin
          far_r[k] <= big_r ||
                      (({1'b0, sqx_r} + {1'b0, sqy_r}) > {1'b0, min_dist_sq_r});
        end
      end
    end else begin : g_far_pass
      always_ff @(posedge clk) begin
        if (en) begin
          far_r[k] <= far_r[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      for (int i = 0; i <= N; i++) begin
        v_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r   <= in_valid;
      v_r[0] <= v1_r;
      for (int i = 1; i <= N; i++) begin
        v_r[i] <= v_r[i-1];
      end
      out_valid_r <= v_r[N];
    end
  end

  // ---------------------------------------------------------------- output stage
  logic [PHASE_W-1:0]       err;
  logic [AW-1:0]            err_q;
  logic                     out_valid_res_r;
  logic signed [AW:0]       out_angle_error_r;

  assign err   = z_r[N] + hoff_r[N];
  assign err_q = err[PHASE_W-1 -: AW];

  always_ff @(posedge clk) begin
    if (en) begin
      out_valid_res_r <= far_r[N];
      if (!far_r[N]) begin
        out_angle_error_r <= '0;
      end else if (err_q == ANGLE_HALF) begin
        // exactly opposite reads as +pi
        out_angle_error_r <= {1'b0, err_q};
      end else begin
        out_angle_error_r <= {err_q[AW-1], err_q};
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_valid_res   = out_valid_res_r;
  assign out_angle_error = out_angle_error_r;

endmodule

`default_nettype wire

// ===== design/bet_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bet_checker
  import bet_pkg::*;
#(
  parameter int unsigned ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         in_stall,
  input wire                         out_valid,
  input wire                         out_stall,
  input wire                         out_valid_res,
  input wire signed [ANGLE_WIDTH:0]  out_angle_error
);

  localparam logic signed [ANGLE_WIDTH:0] ERR_MAX =
    (ANGLE_WIDTH+1)'(1) <<< (ANGLE_WIDTH - 1);
  localparam logic signed [ANGLE_WIDTH:0] ERR_MIN = -ERR_MAX + (ANGLE_WIDTH+1)'(1);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_valid_res) &&
                               $stable(out_angle_error))
    else $error("stalled result changed");

  // input side only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a stalled result");

  a_near_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_angle_error == '0)
    else $error("nonzero error on near request");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> (out_angle_error <= ERR_MAX) &&
                                   (out_angle_error >= ERR_MIN))
    else $error("angle error outside (-pi, pi]");

endmodule

bind bearing_error_to_target bet_checker #(
  .ANGLE_WIDTH(ANGLE_WIDTH)
) u_bet_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_valid_res  (out_valid_res),
  .out_angle_error(out_angle_error)
);

`default_nettype wire
